FILE: rtl/core/per_channel_ratio_ema_tracker_defines.svh
// Assertion helpers for the ratio tracker. Both sample on clk and stay quiet while arst_n is low.
`ifndef PER_CHANNEL_RATIO_EMA_TRACKER_DEFINES_SVH
`define PER_CHANNEL_RATIO_EMA_TRACKER_DEFINES_SVH

// Same-cycle implication.
`define PCRT_ASSERT_HOLDS(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define PCRT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/pcrt_pkg.sv
`default_nettype none
package pcrt_pkg;

	localparam int NUM_CHANNELS    = 16;
	localparam int RATIO_FRAC_BITS = 16;

	localparam int CH_AW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int RATIO_W = 24;
	localparam int CNT_W   = $clog2(RATIO_W);
	localparam int DIV_W   = 31 + RATIO_FRAC_BITS;
	localparam int CMP_W   = 31 + RATIO_W;

	localparam logic [15:0] ALPHA_RESET   = 16'd13107;
	localparam logic [23:0] FLOOR_RESET   = 24'd32768;
	localparam logic [23:0] CEILING_RESET = 24'd262144;
	localparam logic [RATIO_W-1:0] ONE_COR = (RATIO_FRAC_BITS >= RATIO_W) ?
		{RATIO_W{1'b1}} : RATIO_W'(64'd1 << RATIO_FRAC_BITS);

	localparam logic [1:0] CFG_ALPHA   = 2'd0;
	localparam logic [1:0] CFG_FLOOR   = 2'd1;
	localparam logic [1:0] CFG_CEILING = 2'd2;

	typedef enum logic [1:0] {
		MODE_OBSERVE   = 2'd0,
		MODE_QUERY     = 2'd1,
		MODE_CLEAR_ONE = 2'd2,
		MODE_CLEAR_ALL = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_DIV,
		ST_CLAMP,
		ST_MUL,
		ST_SUM,
		ST_WB
	} state_t;

	typedef struct packed {
		mode_t              mode;
		logic [3:0]         channel;
		logic signed [31:0] estimated_count;
		logic signed [31:0] actual_count;
	} cmd_t;

	typedef struct packed {
		logic [23:0] correction;
		logic [31:0] observation_count;
		logic [62:0] sum_estimated;
		logic [62:0] sum_actual;
		logic        has_data;
		logic        accepted;
	} result_t;

	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [31:0]        obs;
		logic [62:0]        est;
		logic [62:0]        act;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

FILE: rtl/core/pcrt_ram.sv
`default_nettype none
module pcrt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/per_channel_ratio_ema_tracker.sv
`default_nettype none
`include "per_channel_ratio_ema_tracker_defines.svh"
// Per-channel ratio tracker. Each channel keeps an exponential moving average of
// actual/estimated (unsigned Q8.16), an observation count and two saturating totals.
// Issue a command by raising start while busy is low. Its single result is marked
// by done, which is high for exactly one cycle, and there is no way to hold it
// off: capture it in that cycle. A new command may start in the same cycle that
// done is high. The steps from start to done depend on the command:
//   - observe that blends into a channel holding data: every step below
//   - observe that seeds an empty channel: the same, without the blend
//   - query, clear, or a rejected observe: table read, check, write-back
// An observe runs through the radix-2 restoring divider, which produces one
// quotient bit per cycle (24 bits). Around it come the table read, the check of
// the entry and divider setup, the clamp, the blend multiply-add (multiply, then
// sum), write-back, and then the registered result shown with done.
// Channel state lives in a single-port-read/single-port-write table.
// "Empty" is tracked with per-channel valid bits that reset clears at once, so
// there is no clearing pass after reset. Configuration writes are always taken
// (cfg_ready is tied high). Perform them only while busy is low and no result is
// pending.
module per_channel_ratio_ema_tracker
	import pcrt_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire cmd_t        cmd,
	output logic             busy,
	output logic             done,
	output result_t          result,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);

	// Clamp: apply the floor first, then the ceiling (the ceiling wins if they cross).
	function automatic logic [RATIO_W-1:0] clamp_ratio(input logic [RATIO_W-1:0] v,
		input logic [RATIO_W-1:0] lo, input logic [RATIO_W-1:0] hi);
		logic [RATIO_W-1:0] r;
		r = v;
		if (r < lo) begin
			r = lo;
		end
		if (r > hi) begin
			r = hi;
		end
		return r;
	endfunction

	// Control and configuration.
	state_t              state_q, state_d;
	logic [NUM_CHANNELS-1:0] valid_q;
	logic                done_q;
	logic [15:0]         alpha_q;
	logic [RATIO_W-1:0]  floor_q;
	logic [RATIO_W-1:0]  ceil_q;

	// Command captured at the start transfer.
	cmd_t                cmd_q;
	logic                inside_q;
	logic                obs_ok_q;
	logic                hit_q;
	entry_t              entry_q;

	// Divider.
	logic [31:0]         rem_q;
	logic [RATIO_W-1:0]  lo_q;
	logic [RATIO_W-1:0]  quo_q;
	logic [CNT_W-1:0]    cnt_q;
	logic                ovf_q;

	// Blend.
	logic [RATIO_W-1:0]  ratio_q;
	logic [39:0]         prod_q;
	logic [40:0]         blend_q;
	result_t             result_q;

	// Table interface.
	logic                rd_en;
	logic                wr_en;
	logic [CH_AW-1:0]    addr;
	logic [ENTRY_W-1:0]  rd_data;
	entry_t              new_entry;

	// Combinational helpers.
	logic                start_xfer;
	logic                inside_in;
	logic                hit_c;
	logic [DIV_W-1:0]    dividend;
	logic                ovf_c;
	logic [31:0]         divisor;
	logic [31:0]         trial;
	logic                ge;
	logic [16:0]         inv_alpha;
	logic [RATIO_W-1:0]  blend_sat;
	logic [63:0]         est_sum;
	logic [63:0]         act_sum;
	entry_t              rep_entry;
	logic                rep_valid;
	result_t             result_d;

	assign cfg_ready  = 1'b1;
	assign start_xfer = start && !busy;
	assign inside_in  = int'(cmd.channel) < NUM_CHANNELS;
	assign addr       = CH_AW'(cmd_q.channel);
	assign hit_c      = inside_q && valid_q[addr];

	// Quotient of (act << F) / est. Anything at or above 2^24 clamps to the ceiling,
	// so detect overflow up front and only develop the low 24 quotient bits.
	assign dividend  = {cmd_q.actual_count[30:0], {RATIO_FRAC_BITS{1'b0}}};
	assign ovf_c     = CMP_W'(dividend) >= {cmd_q.estimated_count[30:0], {RATIO_W{1'b0}}};
	assign divisor   = {1'b0, cmd_q.estimated_count[30:0]};
	assign trial     = {rem_q[30:0], lo_q[RATIO_W-1]};
	assign ge        = trial >= divisor;

	assign inv_alpha = 17'h10000 - {1'b0, alpha_q};
	assign blend_sat = blend_q[40] ? {RATIO_W{1'b1}} : blend_q[39:16];

	pcrt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (NUM_CHANNELS)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (addr),
		.wr_data (new_entry),
		.rd_en   (rd_en),
		.rd_addr (addr),
		.rd_data (rd_data)
	);

	// Write-back values: seed or blended ratio, saturating count and totals.
	always_comb begin
		est_sum = {1'b0, entry_q.est} + 64'(cmd_q.estimated_count[30:0]);
		act_sum = {1'b0, entry_q.act} + 64'(cmd_q.actual_count[30:0]);
		new_entry.ratio = hit_q ? blend_sat : ratio_q;
		new_entry.obs   = (&entry_q.obs) ? entry_q.obs : entry_q.obs + 32'd1;
		new_entry.est   = est_sum[63] ? {63{1'b1}} : est_sum[62:0];
		new_entry.act   = act_sum[63] ? {63{1'b1}} : act_sum[62:0];

		// Report the channel as it stands after this command.
		rep_entry = obs_ok_q ? new_entry : entry_q;
		rep_valid = obs_ok_q ||
			(hit_q && (cmd_q.mode == MODE_OBSERVE || cmd_q.mode == MODE_QUERY));
		result_d.correction        = rep_valid ?
			clamp_ratio(rep_entry.ratio, floor_q, ceil_q) : ONE_COR;
		result_d.observation_count = rep_valid ? rep_entry.obs : '0;
		result_d.sum_estimated     = rep_valid ? rep_entry.est : '0;
		result_d.sum_actual        = rep_valid ? rep_entry.act : '0;
		result_d.has_data          = rep_valid;
		result_d.accepted          = obs_ok_q;
	end

	// Sequencer: next state and strobes.
	always_comb begin
		state_d = state_q;
		busy    = state_q != ST_IDLE;
		rd_en   = state_q == ST_READ;
		wr_en   = (state_q == ST_WB) && obs_ok_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_READ;
				end
			end
			ST_READ:  state_d = ST_CHECK;
			ST_CHECK: state_d = obs_ok_q ? ST_DIV : ST_WB;
			ST_DIV: begin
				if (cnt_q == CNT_W'(RATIO_W - 1)) begin
					state_d = ST_CLAMP;
				end
			end
			ST_CLAMP: state_d = hit_q ? ST_MUL : ST_WB;
			ST_MUL:   state_d = ST_SUM;
			ST_SUM:   state_d = ST_WB;
			ST_WB:    state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= '0;
			done_q  <= 1'b0;
			alpha_q <= ALPHA_RESET;
			floor_q <= FLOOR_RESET;
			ceil_q  <= CEILING_RESET;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == ST_WB;
			if (state_q == ST_WB) begin
				if (obs_ok_q) begin
					valid_q[addr] <= 1'b1;
				end
				if (cmd_q.mode == MODE_CLEAR_ONE && inside_q) begin
					valid_q[addr] <= 1'b0;
				end
				if (cmd_q.mode == MODE_CLEAR_ALL) begin
					valid_q <= '0;
				end
			end
			// Register writes; an index past the list is dropped.
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ALPHA:   alpha_q <= cfg_data[15:0];
					CFG_FLOOR:   floor_q <= cfg_data;
					CFG_CEILING: ceil_q  <= cfg_data;
					default:     ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start_xfer) begin
					cmd_q    <= cmd;
					inside_q <= inside_in;
					// Accept only a positive pair aimed inside the table.
					obs_ok_q <= (cmd.mode == MODE_OBSERVE) && inside_in &&
						(cmd.estimated_count > 0) && (cmd.actual_count > 0);
				end
			end
			ST_CHECK: begin
				// Table data is valid here; a channel without data reads as zero.
				hit_q   <= hit_c;
				entry_q <= hit_c ? entry_t'(rd_data) : '0;
				rem_q   <= 32'(dividend >> RATIO_W);
				lo_q    <= dividend[RATIO_W-1:0];
				quo_q   <= '0;
				cnt_q   <= '0;
				ovf_q   <= ovf_c;
			end
			ST_DIV: begin
				rem_q <= ge ? trial - divisor : trial;
				quo_q <= {quo_q[RATIO_W-2:0], ge};
				lo_q  <= {lo_q[RATIO_W-2:0], 1'b0};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			ST_CLAMP: begin
				ratio_q <= clamp_ratio(ovf_q ? ceil_q : quo_q, floor_q, ceil_q);
			end
			ST_MUL: begin
				prod_q <= {24'b0, alpha_q} * {16'b0, ratio_q};
			end
			ST_SUM: begin
				// Round half up before the shift by 16.
				blend_q <= {1'b0, prod_q} + ({24'b0, inv_alpha} * {17'b0, entry_q.ratio})
					+ 41'd32768;
			end
			ST_WB: begin
				result_q <= result_d;
			end
			default: ;
		endcase
	end

	assign done   = done_q;
	assign result = result_q;

	`PCRT_ASSERT_HOLDS(a_done_not_busy, done, !busy, "result strobe while still busy")
	`PCRT_ASSERT_HOLDS(a_accept_has_data, done && result.accepted, result.has_data,
		"recorded observation reports an empty channel")
	`PCRT_ASSERT_NEXT(a_start_busy, start && !busy, busy, "start transfer did not raise busy")
	`PCRT_ASSERT_NEXT(a_div_exit, state_q == ST_DIV,
		state_q == ST_DIV || state_q == ST_CLAMP, "divider left to an unexpected state")

endmodule
`default_nettype wire

FILE: tb/sv/tb_per_channel_ratio_ema_tracker.sv
`default_nettype none
module tb_per_channel_ratio_ema_tracker;
	import pcrt_pkg::*;

	// Run shape: one directed table, then several register settings with random
	// traffic behind each. The stall limit covers the slowest observe plus the
	// longest sender gap many times over.
	localparam int ITEMS_PER_PHASE = 270;
	localparam int NUM_PHASES      = 7;
	localparam int STALL_LIMIT     = 2000;
	localparam int TAIL_CYCLES     = 40;
	localparam int PRINT_CAP       = 100;

	logic        clk;
	logic        arst_n;
	logic        start;
	cmd_t        cmd;
	logic        busy;
	logic        done;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [23:0] cfg_data;

	per_channel_ratio_ema_tracker u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.busy      (busy),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4-unit clock period.
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Shadow copy of the channel table and the three registers.
	logic [15:0] shadow_alpha;
	logic [23:0] shadow_floor;
	logic [23:0] shadow_ceiling;
	logic        chan_valid [NUM_CHANNELS];
	logic [23:0] chan_ratio [NUM_CHANNELS];
	logic [31:0] chan_obs   [NUM_CHANNELS];
	logic [62:0] chan_est   [NUM_CHANNELS];
	logic [62:0] chan_act   [NUM_CHANNELS];

	// Results still owed by the block, oldest first.
	result_t pending_results [$];

	// A directed row may carry a hand-typed result; it replaces the prediction.
	bit      use_typed;
	result_t typed_res;

	int error_count;
	int stall_cycles;
	int n_cmds;
	int n_obs_recorded;
	int n_obs_rejected;
	int n_queries;
	int n_clears;
	int n_settings;

	typedef struct packed {
		cmd_t    c;
		bit      known;
		result_t res;
	} dir_row_t;

	// Directed stimulus table, walked in order.
	dir_row_t rows [$];

	function automatic void clear_channel(int unsigned ch);
		chan_valid[ch] = 1'b0;
		chan_ratio[ch] = '0;
		chan_obs[ch]   = '0;
		chan_est[ch]   = '0;
		chan_act[ch]   = '0;
	endfunction

	// Floor first, ceiling second: with floor above ceiling the ceiling wins.
	function automatic logic [63:0] bound_ratio(logic [63:0] v);
		if (v < 64'(shadow_floor)) v = 64'(shadow_floor);
		if (v > 64'(shadow_ceiling)) v = 64'(shadow_ceiling);
		if (v > 64'hFF_FFFF) v = 64'hFF_FFFF;
		return v;
	endfunction

	function automatic logic [62:0] add_sat63(logic [62:0] a, logic [31:0] b);
		logic [63:0] s;
		s = {1'b0, a} + 64'(b);
		return s[63] ? {63{1'b1}} : s[62:0];
	endfunction

	// Apply one command to the shadow table and return the result it must produce.
	function automatic result_t apply_to_table(cmd_t c);
		result_t     r;
		int unsigned ch;
		logic [63:0] est;
		logic [63:0] act;
		logic [63:0] q;
		logic [63:0] blend;
		logic [63:0] cor;
		bit          ok;
		ch  = c.channel;
		est = {32'd0, c.estimated_count};
		act = {32'd0, c.actual_count};
		r   = '0;
		case (c.mode)
			MODE_OBSERVE: begin
				// Zero or sign bit set on either count rejects the observation.
				ok = (est != 0) && !est[31] && (act != 0) && !act[31];
				if (ok) begin
					q = bound_ratio((act << RATIO_FRAC_BITS) / est);
					if (!chan_valid[ch]) begin
						chan_ratio[ch] = q[23:0];
					end else begin
						blend = 64'(shadow_alpha) * q
							+ (64'd65536 - 64'(shadow_alpha)) * 64'(chan_ratio[ch])
							+ 64'd32768;
						blend = blend >> 16;
						chan_ratio[ch] = (blend > 64'hFF_FFFF) ? 24'hFF_FFFF : blend[23:0];
					end
					chan_valid[ch] = 1'b1;
					if (chan_obs[ch] != '1) chan_obs[ch] = chan_obs[ch] + 32'd1;
					chan_est[ch] = add_sat63(chan_est[ch], est[31:0]);
					chan_act[ch] = add_sat63(chan_act[ch], act[31:0]);
					r.accepted   = 1'b1;
				end
			end
			MODE_CLEAR_ONE: clear_channel(ch);
			MODE_CLEAR_ALL: begin
				for (int i = 0; i < NUM_CHANNELS; i++) clear_channel(i);
			end
			default: ;
		endcase
		// Report the state after the command; empty channels read as 1.0.
		if (chan_valid[ch]) begin
			cor                 = bound_ratio(64'(chan_ratio[ch]));
			r.correction        = cor[23:0];
			r.observation_count = chan_obs[ch];
			r.sum_estimated     = chan_est[ch];
			r.sum_actual        = chan_act[ch];
			r.has_data          = 1'b1;
		end else begin
			r.correction = ONE_COR;
		end
		return r;
	endfunction

	function automatic cmd_t mk_cmd(mode_t m, logic [3:0] ch, logic [31:0] est,
			logic [31:0] act);
		cmd_t c;
		c.mode            = m;
		c.channel         = ch;
		c.estimated_count = est;
		c.actual_count    = act;
		return c;
	endfunction

	function automatic result_t mk_res(logic [23:0] cor, logic [31:0] obs,
			logic [62:0] est, logic [62:0] act, logic has, logic acc);
		result_t r;
		r.correction        = cor;
		r.observation_count = obs;
		r.sum_estimated     = est;
		r.sum_actual        = act;
		r.has_data          = has;
		r.accepted          = acc;
		return r;
	endfunction

	function automatic dir_row_t mk_row(cmd_t c, bit known, result_t res);
		dir_row_t row;
		row.c     = c;
		row.known = known;
		row.res   = res;
		return row;
	endfunction

	// Append one row to the directed table.
	function automatic void add_row(dir_row_t row);
		rows = {rows, row};
	endfunction

	// Count generator: mostly positive, with zero, negative and the
	// most-negative value mixed in so the reject path and bit 31 get exercised.
	function automatic logic [31:0] rand_count();
		int unsigned r;
		logic [31:0] w;
		r = $urandom_range(0, 99);
		w = $urandom;
		if (r < 4) return 32'd0;
		if (r < 9) return {1'b1, w[30:0]};
		if (r < 11) return 32'h8000_0000;
		if (r < 13) return 32'h7FFF_FFFF;
		if (r < 45) return 32'($urandom_range(1, 1000));
		if (r < 75) return 32'($urandom_range(1, 65535));
		if (w[30:0] == 0) return 32'd1;
		return {1'b0, w[30:0]};
	endfunction

	function automatic cmd_t random_cmd();
		cmd_t        c;
		int unsigned r;
		logic [63:0] scaled;
		r         = $urandom_range(0, 99);
		c.channel = 4'($urandom_range(0, NUM_CHANNELS - 1));
		c.estimated_count = rand_count();
		c.actual_count    = rand_count();
		if (r < 62) begin
			c.mode = MODE_OBSERVE;
			// Tie actual to estimated often so ratios land inside the bounds.
			if ($urandom_range(0, 99) < 45 && !c.estimated_count[31]
					&& c.estimated_count != 0) begin
				scaled = (64'(c.estimated_count) * 64'($urandom_range(1, 48))) >> 4;
				if (scaled == 0) scaled = 64'd1;
				if (scaled > 64'h7FFF_FFFF) scaled = 64'h7FFF_FFFF;
				c.actual_count = scaled[31:0];
			end
		end else if (r < 87) begin
			c.mode = MODE_QUERY;
		end else if (r < 97) begin
			c.mode = MODE_CLEAR_ONE;
		end else begin
			c.mode = MODE_CLEAR_ALL;
		end
		return c;
	endfunction

	// One line per mismatch; printing stops past the cap but counting goes on.
	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (error_count < PRINT_CAP)
			$display("MISMATCH %s: got 0x%0h, expected 0x%0h", what, got, want);
		error_count++;
	endtask

	task automatic compare_result(result_t got, result_t want);
		if (got.correction !== want.correction)
			report_mismatch("correction", 64'(got.correction), 64'(want.correction));
		if (got.observation_count !== want.observation_count)
			report_mismatch("observation_count", 64'(got.observation_count),
				64'(want.observation_count));
		if (got.sum_estimated !== want.sum_estimated)
			report_mismatch("sum_estimated", 64'(got.sum_estimated),
				64'(want.sum_estimated));
		if (got.sum_actual !== want.sum_actual)
			report_mismatch("sum_actual", 64'(got.sum_actual), 64'(want.sum_actual));
		if (got.has_data !== want.has_data)
			report_mismatch("has_data", 64'(got.has_data), 64'(want.has_data));
		if (got.accepted !== want.accepted)
			report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
	endtask

	// Monitor: sample everything at the rising edge. Retire the finishing result
	// before predicting a command taken in the same cycle.
	always @(posedge clk) begin
		result_t want;
		if (arst_n) begin
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing outstanding", 64'(result.correction),
						64'd0);
				end else begin
					want = pending_results.pop_front();
					compare_result(result, want);
				end
			end
			if (start && !busy) begin
				want = apply_to_table(cmd);
				if (want.accepted) n_obs_recorded++;
				else if (cmd.mode == MODE_OBSERVE) n_obs_rejected++;
				else if (cmd.mode == MODE_QUERY) n_queries++;
				else n_clears++;
				if (use_typed) want = typed_res;
				pending_results = {pending_results, want};
				n_cmds++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA:   shadow_alpha   = cfg_data[15:0];
					CFG_FLOOR:   shadow_floor   = cfg_data;
					CFG_CEILING: shadow_ceiling = cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Watchdog: any transfer on any channel resets the count of dead cycles.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	// Present one command at the falling edge and hold it until the transfer.
	// Start stays high on return so back-to-back commands need no re-raise.
	task automatic issue_cmd(cmd_t c, bit known, result_t res);
		use_typed = known;
		typed_res = res;
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
		@(negedge clk);
	endtask

	// Drop start for a random gap, long enough to land on any stage of an observe.
	task automatic maybe_idle();
		if ($urandom_range(0, 99) < 29) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 40)) @(negedge clk);
		end
	endtask

	// Hold off new commands until every owed result has come back.
	task automatic drain();
		start <= 1'b0;
		@(negedge clk);
		while (pending_results.size() != 0 || busy) @(negedge clk);
	endtask

	// Write all three registers back to back; valid drops only after the last.
	task automatic set_config(logic [23:0] alpha_word, logic [23:0] floor_word,
			logic [23:0] ceiling_word);
		logic [23:0] words [3];
		words[0] = alpha_word;
		words[1] = floor_word;
		words[2] = ceiling_word;
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= (i == 0) ? CFG_ALPHA : (i == 1) ? CFG_FLOOR : CFG_CEILING;
			cfg_data  <= words[i];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		n_settings++;
	endtask

	initial begin
		result_t     empty_res;
		result_t     none_res;
		logic [23:0] rand_alpha;
		logic [23:0] rand_floor;
		logic [23:0] rand_ceiling;

		// Drive every input to a known value before the first edge.
		arst_n    = 1'b0;
		start     = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ALPHA;
		cfg_data  = '0;
		use_typed = 1'b0;
		typed_res = '0;
		error_count    = 0;
		stall_cycles   = 0;
		n_cmds         = 0;
		n_obs_recorded = 0;
		n_obs_rejected = 0;
		n_queries      = 0;
		n_clears       = 0;
		n_settings     = 1;
		shadow_alpha   = ALPHA_RESET;
		shadow_floor   = FLOOR_RESET;
		shadow_ceiling = CEILING_RESET;
		for (int i = 0; i < NUM_CHANNELS; i++) clear_channel(i);

		empty_res = mk_res(ONE_COR, 32'd0, 63'd0, 63'd0, 1'b0, 1'b0);
		none_res  = '0;

		// Directed table under the reset register values (alpha 0.2, bounds 0.5..4.0).
		// Fresh table: any query reads as empty.
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd0, 32'd0, 32'd0), 1'b1, empty_res));
		// Rejects: zero estimate, negative estimate, most-negative actual.
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd0, 32'd0, 32'd5), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd0, 32'hFFFF_FFFF, 32'd5), 1'b1,
			empty_res));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd0, 32'd5, 32'h8000_0000), 1'b1,
			empty_res));
		// Tiny ratio clamps to the floor; huge ratio clamps to the ceiling.
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd0, 32'h7FFF_FFFF, 32'd1), 1'b1,
			mk_res(24'd32768, 32'd1, 63'h7FFF_FFFF, 63'd1, 1'b1, 1'b1)));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd1, 32'd1, 32'h7FFF_FFFF), 1'b1,
			mk_res(24'd262144, 32'd1, 63'd1, 63'h7FFF_FFFF, 1'b1, 1'b1)));
		// Seed at exactly 1.0, then blend twice.
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd2, 32'd100, 32'd100), 1'b1,
			mk_res(24'd65536, 32'd1, 63'd100, 63'd100, 1'b1, 1'b1)));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd2, 32'd100, 32'd200), 1'b0, none_res));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd2, 32'd3, 32'd1), 1'b0, none_res));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd2, 32'd0, 32'd0), 1'b0, none_res));
		// Reject on a channel with data reports its current statistics.
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd2, 32'd0, 32'd0), 1'b0, none_res));
		// Top channel, ratio 1.5.
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd15, 32'd1000, 32'd1500), 1'b1,
			mk_res(24'd98304, 32'd1, 63'd1000, 63'd1500, 1'b1, 1'b1)));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
			1'b0, none_res));
		// Clear one channel, confirm it reads empty, others untouched.
		add_row(mk_row(mk_cmd(MODE_CLEAR_ONE, 4'd2, 32'd0, 32'd0), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd2, 32'd0, 32'd0), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd1, 32'd0, 32'd0), 1'b0, none_res));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF),
			1'b0, none_res));
		// Clear all, then channels 15 and 1 read empty, and a reject on channel 3 too.
		add_row(mk_row(mk_cmd(MODE_CLEAR_ALL, 4'd0, 32'd0, 32'd0), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd15, 32'd0, 32'd0), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_QUERY, 4'd1, 32'd0, 32'd0), 1'b1, empty_res));
		add_row(mk_row(mk_cmd(MODE_OBSERVE, 4'd3, 32'h8000_0000, 32'h8000_0000),
			1'b1, empty_res));

		// Hold reset, then release it on a falling edge.
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			issue_cmd(rows[i].c, rows[i].known, rows[i].res);
			maybe_idle();
		end
		drain();

		// Random phases, each behind its own register setting. Stored averages
		// carry across settings, so queries re-clamp old data under new bounds.
		for (int p = 0; p < NUM_PHASES; p++) begin
			rand_alpha   = 24'($urandom);
			rand_floor   = 24'($urandom_range(0, 65536));
			rand_ceiling = 24'($urandom_range(65536, 24'h08_0000));
			case (p)
				0: set_config(24'h00_FFFF, 24'd0, 24'hFF_FFFF);
				1: set_config(24'd0, 24'd0, 24'hFF_FFFF);
				2: set_config({8'd0, rand_alpha[15:0]}, rand_floor, rand_ceiling);
				// Floor above ceiling: the ceiling wins everywhere.
				3: set_config(24'd32768, 24'd200000, 24'd40000);
				4: set_config(24'd1, 24'hFF_FFFF, 24'hFF_FFFF);
				5: set_config({8'd0, rand_alpha[15:0]}, 24'd0, 24'd0);
				default: set_config(rand_alpha, 24'($urandom), 24'($urandom));
			endcase
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				issue_cmd(random_cmd(), 1'b0, none_res);
				// Phase 2 skips the random sender gaps; only the rare drain pauses it.
				if (p != 2) maybe_idle();
				if ($urandom_range(0, 199) == 0) drain();
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never returned", 64'(pending_results.size()), 64'd0);

		$display("Covered %0d commands over %0d register settings: %0d observes recorded,",
			n_cmds, n_settings, n_obs_recorded);
		$display("  %0d observes rejected, %0d queries, %0d clears; %0d mismatches",
			n_obs_rejected, n_queries, n_clears, error_count);
		if (error_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
